// File: sv/keyframe_retaining_segment_index_defines.svh
// Assertion macros shared by the segment index RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef KEYFRAME_RETAINING_SEGMENT_INDEX_DEFINES_SVH
`define KEYFRAME_RETAINING_SEGMENT_INDEX_DEFINES_SVH

// expr must hold at every clock edge out of reset
`define KRSI_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expr");

// cons must hold whenever ante holds
`define KRSI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante -> cons");

`endif

// File: sv/krsi_pkg.sv
// Types and constants of the segment index.
// No dependencies; imported by every other file but the assertion macro header.
`timescale 1ns / 1ps
package krsi_pkg;
   localparam int OP_W       = 2;
   localparam int TIME_W     = 40;
   localparam int SEQ_W      = 32;
   localparam int HANDLE_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int HELD_W     = 7;
   localparam int WINDOW_W   = 32;

   // request op codes
   localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND = 2'd1;
   localparam logic [OP_W-1:0] OP_KEY  = 2'd2;

   // classified request kinds
   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_FIND = 2'd1;
   localparam logic [1:0] KIND_KEY  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   typedef struct packed {
      logic [1:0]          kind;
      logic [TIME_W-1:0]   time_ms;
      logic                is_keyframe;
      logic [HANDLE_W-1:0] payload_handle;
      logic [SEQ_W-1:0]    query_seq;
   } req_item_type;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [TIME_W-1:0]   time_ms;
      logic                key;
      logic [HANDLE_W-1:0] handle;
   } seg_entry_type;
endpackage

// File: sv/krsi_if.sv
// Request and response channel interfaces of the segment index.
// Depends on krsi_pkg for field widths.
`timescale 1ns / 1ps
interface krsi_req_if import krsi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [TIME_W-1:0]   time_ms;
   logic                is_keyframe;
   logic [HANDLE_W-1:0] payload_handle;
   logic [SEQ_W-1:0]    query_seq;
   modport source (output valid, op, time_ms, is_keyframe, payload_handle, query_seq,
                   input ready);
   modport sink (input valid, op, time_ms, is_keyframe, payload_handle, query_seq,
                 output ready);
endinterface

interface krsi_rsp_if import krsi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SEQ_W-1:0]    entry_seq;
   logic [TIME_W-1:0]   entry_time_ms;
   logic                entry_keyframe;
   logic [HANDLE_W-1:0] entry_handle;
   logic [HELD_W-1:0]   held_count;
   modport source (output valid, status, entry_seq, entry_time_ms, entry_keyframe,
                   entry_handle, held_count, input ready);
   modport sink (input valid, status, entry_seq, entry_time_ms, entry_keyframe,
                 entry_handle, held_count, output ready);
endinterface

// File: sv/krsi_front.sv
// Front end: accepts requests, classifies the op and queues them (two entries).
// Depends on krsi_pkg and krsi_req_if.
`timescale 1ns / 1ps
module krsi_front import krsi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   krsi_req_if.sink     req_if,
   output logic         q_valid,
   output req_item_type q_item,
   input  logic         q_pop
);
   req_item_type slot_ff [2];
   req_item_type slot_in [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push, pop;
   req_item_type new_item;

   always_comb begin
      case (req_if.op)
         OP_ADD:  new_item.kind = KIND_ADD;
         OP_FIND: new_item.kind = KIND_FIND;
         OP_KEY:  new_item.kind = KIND_KEY;
         default: new_item.kind = KIND_NONE;
      endcase
      new_item.time_ms        = req_if.time_ms;
      new_item.is_keyframe    = req_if.is_keyframe;
      new_item.payload_handle = req_if.payload_handle;
      new_item.query_seq      = req_if.query_seq;
   end

   assign req_if.ready = (fill_ff != 2'd2);
   assign q_valid      = (fill_ff != 2'd0);
   assign q_item       = slot_ff[rd_ptr_ff];
   assign push         = req_if.valid && req_if.ready;
   assign pop          = q_pop && q_valid;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = new_item;
         wr_ptr_in          = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end
endmodule

// File: sv/krsi_back.sv
// Back end: segment store, FIFO bookkeeping, drop sequencer and response register.
// Depends on krsi_pkg, krsi_rsp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "keyframe_retaining_segment_index_defines.svh"
module krsi_back import krsi_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [WINDOW_W-1:0] keep_window_ms,
   input  logic                q_valid,
   input  req_item_type        q_item,
   output logic                q_pop,
   krsi_rsp_if.source          rsp_if
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_USE  = 2'd2;

   seg_entry_type mem [DEPTH];
   seg_entry_type rd_data_ff;
   seg_entry_type mem_wdata;
   logic [AW-1:0] mem_waddr;
   logic          mem_we;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          kind_ff, kind_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic [AW-1:0]       oldest_ff, oldest_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       keys_ff, keys_in;
   logic [AW-1:0]       newest_key_ff, newest_key_in;
   logic [SEQ_W-1:0]    next_seq_ff, next_seq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   seg_entry_type       rsp_entry_ff, rsp_entry_in;
   logic [HELD_W-1:0]   held_ff, held_in;

   logic [SW-1:0]    wsum, fsum, osum;
   logic [AW-1:0]    wslot, fslot, oldest_next;
   logic [SEQ_W-1:0] base_seq, dq;
   logic             q_at_base, found;
   logic [CW-1:0]    fpos;
   logic [TIME_W-1:0] age;
   logic             drop;

   // slot arithmetic: sums stay below twice the depth
   always_comb begin
      wsum = SW'(oldest_ff) + SW'(count_ff);
      if (wsum >= SW'(DEPTH)) wsum = wsum - SW'(DEPTH);
      wslot = wsum[AW-1:0];
      osum = SW'(oldest_ff) + SW'(1);
      if (osum >= SW'(DEPTH)) osum = osum - SW'(DEPTH);
      oldest_next = osum[AW-1:0];
      // held sequences are consecutive, so a find is a direct offset
      base_seq  = next_seq_ff - SEQ_W'(count_ff);
      dq        = q_item.query_seq - base_seq;
      q_at_base = (q_item.query_seq <= base_seq);
      found     = (count_ff != '0) && (q_at_base || (dq < SEQ_W'(count_ff)));
      fpos      = q_at_base ? '0 : dq[CW-1:0];
      fsum = SW'(oldest_ff) + SW'(fpos);
      if (fsum >= SW'(DEPTH)) fsum = fsum - SW'(DEPTH);
      fslot = fsum[AW-1:0];
      age  = time_ff - rd_data_ff.time_ms;
      drop = (count_ff > CW'(1)) && (time_ff > rd_data_ff.time_ms)
             && (age > TIME_W'(keep_window_ms))
             && (keys_ff != CW'(rd_data_ff.key));
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      time_in       = time_ff;
      rd_addr_in    = rd_addr_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      keys_in       = keys_ff;
      newest_key_in = newest_key_ff;
      next_seq_in   = next_seq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      status_in     = status_ff;
      rsp_entry_in  = rsp_entry_ff;
      held_in       = held_ff;
      mem_we        = 1'b0;
      mem_waddr     = wslot;
      mem_wdata     = '{next_seq_ff, q_item.time_ms, q_item.is_keyframe,
                        q_item.payload_handle};
      q_pop         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop        = 1'b1;
               kind_in      = q_item.kind;
               time_in      = q_item.time_ms;
               status_in    = STATUS_NONE;
               rsp_entry_in = '0;
               held_in      = HELD_W'(count_ff);
               rsp_valid_in = 1'b1;
               case (q_item.kind)
                  KIND_ADD: begin
                     if (count_ff == CW'(DEPTH) || next_seq_ff == SEQ_MAX) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        status_in    = STATUS_OK;
                        rsp_entry_in = mem_wdata;
                        rsp_valid_in = 1'b0;
                        count_in     = count_ff + CW'(1);
                        next_seq_in  = next_seq_ff + SEQ_W'(1);
                        keys_in      = keys_ff + CW'(q_item.is_keyframe);
                        if (q_item.is_keyframe) newest_key_in = wslot;
                        rd_addr_in   = oldest_ff;
                        state_in     = ST_WAIT;
                     end
                  end
                  KIND_FIND: begin
                     if (found) begin
                        rd_addr_in   = fslot;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_WAIT;
                     end
                  end
                  KIND_KEY: begin
                     if (keys_ff != '0) begin
                        rd_addr_in   = newest_key_ff;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WAIT: begin
            state_in = ST_USE;
         end
         ST_USE: begin
            if (kind_ff == KIND_ADD && drop) begin
               oldest_in  = oldest_next;
               count_in   = count_ff - CW'(1);
               keys_in    = keys_ff - CW'(rd_data_ff.key);
               rd_addr_in = oldest_next;
               state_in   = ST_WAIT;
            end else begin
               if (kind_ff != KIND_ADD) begin
                  status_in    = STATUS_OK;
                  rsp_entry_in = rd_data_ff;
               end
               held_in      = HELD_W'(count_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      time_ff       <= time_in;
      rd_addr_ff    <= rd_addr_in;
      newest_key_ff <= newest_key_in;
      status_ff     <= status_in;
      rsp_entry_ff  <= rsp_entry_in;
      held_ff       <= held_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         keys_ff      <= '0;
         next_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         keys_ff      <= keys_in;
         next_seq_ff  <= next_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.entry_seq      = rsp_entry_ff.seq;
   assign rsp_if.entry_time_ms  = rsp_entry_ff.time_ms;
   assign rsp_if.entry_keyframe = rsp_entry_ff.key;
   assign rsp_if.entry_handle   = rsp_entry_ff.handle;
   assign rsp_if.held_count     = held_ff;

   `KRSI_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `KRSI_ASSERT_ALWAYS(a_keys_bound, clock, reset, keys_ff <= count_ff)
   `KRSI_ASSERT_IMPLY(a_drop_keeps_one, clock, reset, state_ff == ST_USE && state_in == ST_WAIT, count_ff > CW'(1))
endmodule

// File: sv/keyframe_retaining_segment_index.sv
// Keyframe-retaining segment index: FIFO of up to DEPTH segments with sequence
// numbering, window-based aging that keeps a keyframe, find and newest-key queries.
// Each request produces exactly one response. A refused add, an unknown op or a missed
// find or newest-keyframe query is answered from idle; a hit reads the store via the
// wait and use states. An accepted add writes the store, then the drop sequencer walks
// the oldest entries one at a time over the single store read port, via wait and use
// for each. A two entry request queue lets new requests land while the back end works;
// the response register holds a result until taken. Store entries are not cleared;
// only held entries are ever read. Depends on krsi_pkg, krsi_if, krsi_front, krsi_back.
`timescale 1ns / 1ps
module keyframe_retaining_segment_index import krsi_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   krsi_req_if.sink            req_if,
   krsi_rsp_if.source          rsp_if,
   input  logic                csr_we,
   input  logic [WINDOW_W-1:0] csr_wdata
);
   logic [WINDOW_W-1:0] keep_window_ff;
   logic                q_valid;
   logic                q_pop;
   req_item_type        q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_window_ff <= WINDOW_W'(3000);
      end else if (csr_we) begin
         keep_window_ff <= csr_wdata;
      end
   end

   krsi_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   krsi_back #(.DEPTH(DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .keep_window_ms (keep_window_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_if         (rsp_if)
   );
endmodule

// File: tb/sv/keyframe_retaining_segment_index_tb.sv
// Self-checking testbench for the keyframe-retaining segment index.
// Depends on krsi_pkg, krsi_if and the keyframe_retaining_segment_index RTL.
`timescale 1ns / 1ps
module keyframe_retaining_segment_index_tb import krsi_pkg::*; ();

   localparam int DEPTH = 64;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 200;
   localparam int PEND_DEPTH = 256;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SEQ_W-1:0]    seq;
      logic [TIME_W-1:0]   time_ms;
      logic                key;
      logic [HANDLE_W-1:0] handle;
      logic [HELD_W-1:0]   held;
   } index_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [WINDOW_W-1:0] csr_wdata;

   krsi_req_if req_bus();
   krsi_rsp_if rsp_bus();

   keyframe_retaining_segment_index #(.DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // mirror of the index state
   logic [SEQ_W-1:0]    mir_seq [DEPTH];
   logic [TIME_W-1:0]   mir_time [DEPTH];
   logic                mir_key [DEPTH];
   logic [HANDLE_W-1:0] mir_handle [DEPTH];
   int unsigned         mir_oldest;
   int unsigned         mir_count;
   logic [SEQ_W-1:0]    mir_next_seq;
   logic [WINDOW_W-1:0] mir_window;

   // expected responses, in request order
   index_result_type pending_results [PEND_DEPTH];
   int  pend_wr;
   int  pend_rd;
   int  error_count;
   bit  quiet;
   int  hold_left;
   logic [TIME_W-1:0] clip_time;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end

   function automatic index_result_type result_of(logic [STATUS_W-1:0] st, int slot);
      index_result_type r;
      r.status = st;
      r.seq = '0;
      r.time_ms = '0;
      r.key = 1'b0;
      r.handle = '0;
      if (slot >= 0) begin
         r.seq = mir_seq[slot];
         r.time_ms = mir_time[slot];
         r.key = mir_key[slot];
         r.handle = mir_handle[slot];
      end
      r.held = mir_count[HELD_W-1:0];
      return r;
   endfunction

   function automatic bit keyframe_after_oldest();
      for (int unsigned i = 1; i < mir_count; i++)
         if (mir_key[(mir_oldest + i) % DEPTH]) return 1'b1;
      return 1'b0;
   endfunction

   // next result of the index for one accepted request
   function automatic index_result_type index_lookup(logic [OP_W-1:0] op,
                                                     logic [TIME_W-1:0] t,
                                                     logic key, logic [HANDLE_W-1:0] h,
                                                     logic [SEQ_W-1:0] q);
      int s;
      logic [TIME_W-1:0] old;
      case (op)
         OP_ADD: begin
            if (mir_count >= DEPTH || mir_next_seq == SEQ_MAX) return result_of(STATUS_FULL, -1);
            s = (mir_oldest + mir_count) % DEPTH;
            mir_seq[s] = mir_next_seq;
            mir_time[s] = t;
            mir_key[s] = key;
            mir_handle[s] = h;
            mir_next_seq++;
            mir_count++;
            while (mir_count > 1) begin
               old = mir_time[mir_oldest];
               if (!(t > old && (t - old) > {8'd0, mir_window})) break;
               if (!keyframe_after_oldest()) break;
               mir_oldest = (mir_oldest + 1) % DEPTH;
               mir_count--;
            end
            return result_of(STATUS_OK, s);
         end
         OP_FIND: begin
            for (int unsigned i = 0; i < mir_count; i++) begin
               s = (mir_oldest + i) % DEPTH;
               if (mir_seq[s] >= q) return result_of(STATUS_OK, s);
            end
            return result_of(STATUS_NONE, -1);
         end
         OP_KEY: begin
            for (int i = mir_count; i > 0; i--) begin
               s = (mir_oldest + i - 1) % DEPTH;
               if (mir_key[s]) return result_of(STATUS_OK, s);
            end
            return result_of(STATUS_NONE, -1);
         end
         default: return result_of(STATUS_NONE, -1);
      endcase
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
   endtask

   // response side: random stalls plus an optional long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
         end
      end
   end

   always @(posedge clock) begin
      index_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pend_wr == pend_rd) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_results[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.entry_seq !== want.seq)
               report_mismatch("entry_seq", rsp_bus.entry_seq, want.seq);
            if (rsp_bus.entry_time_ms !== want.time_ms)
               report_mismatch("entry_time_ms", rsp_bus.entry_time_ms, want.time_ms);
            if (rsp_bus.entry_keyframe !== want.key)
               report_mismatch("entry_keyframe", rsp_bus.entry_keyframe, want.key);
            if (rsp_bus.entry_handle !== want.handle)
               report_mismatch("entry_handle", rsp_bus.entry_handle, want.handle);
            if (rsp_bus.held_count !== want.held)
               report_mismatch("held_count", rsp_bus.held_count, want.held);
         end
      end
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] t, logic key,
                               logic [HANDLE_W-1:0] h, logic [SEQ_W-1:0] q);
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.time_ms <= t;
      req_bus.is_keyframe <= key;
      req_bus.payload_handle <= h;
      req_bus.query_seq <= q;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results[pend_wr % PEND_DEPTH] = index_lookup(op, t, key, h, q);
      pend_wr++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic set_window(logic [WINDOW_W-1:0] w);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      mir_window = w;
   endtask

   task automatic add_segment(logic [TIME_W-1:0] t, logic key);
      send_request(OP_ADD, t, key, 16'($urandom), '0);
   endtask

   task automatic test_directed();
      send_request(OP_FIND, '0, 1'b0, '0, '0);          // empty index
      send_request(OP_KEY, '0, 1'b0, '0, '0);
      send_request(OP_UNUSED, '1, 1'b1, '1, '1);
      send_request(OP_ADD, '0, 1'b1, '0, '0);
      send_request(OP_ADD, 40'd1000, 1'b0, 16'hffff, '1);
      send_request(OP_ADD, 40'd2000, 1'b1, 16'h5a5a, '0);
      send_request(OP_FIND, '0, 1'b0, '0, '0);
      send_request(OP_FIND, '0, 1'b0, '0, 32'd1);
      send_request(OP_FIND, '0, 1'b0, '0, SEQ_MAX);
      send_request(OP_KEY, '0, 1'b0, '0, '0);
      // far jump: old entries age out down to the newest keyframe
      send_request(OP_ADD, '1, 1'b0, 16'h1234, '0);
      // time going backwards drops nothing
      send_request(OP_ADD, 40'd5, 1'b1, 16'h0001, '0);
      send_request(OP_ADD, 40'd6, 1'b0, 16'h8000, '0);
      send_request(OP_KEY, '0, 1'b0, '0, '0);
      send_request(OP_UNUSED, '0, 1'b0, '0, '0);
      send_request(OP_FIND, '0, 1'b0, '0, 32'd3);
   endtask

   // no aging: fill until adds are refused, then age out in one step
   task automatic test_full_store();
      logic [TIME_W-1:0] t;
      set_window('1);
      t = 40'd100;
      for (int i = 0; i < DEPTH + 3; i++) begin
         add_segment(t, i % 9 == 0);
         t += 40'd10;
      end
      send_request(OP_KEY, '0, 1'b0, '0, '0);
      send_request(OP_FIND, '0, 1'b0, '0, mir_next_seq - 32'd5);
      set_window('0);
      add_segment(t + 40'd1, 1'b1);
      send_request(OP_FIND, '0, 1'b0, '0, '0);
   endtask

   task automatic random_phase(int items, logic [WINDOW_W-1:0] w, int max_step);
      int pick;
      set_window(w);
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 19) == 0) clip_time = {8'($urandom), 32'($urandom)};
            else clip_time += 40'($urandom_range(0, max_step));
            add_segment(clip_time, $urandom_range(0, 3) == 0);
         end else if (pick < 80) begin
            send_request(OP_FIND, {8'($urandom), 32'($urandom)}, 1'($urandom), 16'($urandom),
                         ($urandom_range(0, 9) == 0) ? 32'($urandom)
                            : mir_next_seq - 32'($urandom_range(0, 70)));
         end else if (pick < 95) begin
            send_request(OP_KEY, {8'($urandom), 32'($urandom)}, 1'($urandom), 16'($urandom),
                         32'($urandom));
         end else begin
            send_request(OP_UNUSED, {8'($urandom), 32'($urandom)}, 1'($urandom),
                         16'($urandom), 32'($urandom));
         end
      end
   endtask

   task automatic test_random();
      random_phase(250, 32'd3000, 800);
      random_phase(200, 32'd0, 50);
      random_phase(200, 32'd20000, 600);
      hold_left = 400;                 // sender keeps offering while responses back up
      random_phase(150, 32'd1500, 400);
      random_phase(200, 32'hffffffff, 1000);
      quiet = 1'b1;
      random_phase(200, 32'd2500, 700);
   endtask

   initial begin
      error_count = 0;
      pend_wr = 0;
      pend_rd = 0;
      quiet = 1'b0;
      hold_left = 0;
      clip_time = '0;
      mir_oldest = 0;
      mir_count = 0;
      mir_next_seq = '0;
      mir_window = 32'd3000;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_ADD;
      req_bus.time_ms <= '0;
      req_bus.is_keyframe <= 1'b0;
      req_bus.payload_handle <= '0;
      req_bus.query_seq <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_random();
      req_bus.valid <= 1'b0;
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
